>>> design/assert_macros.svh
// Assertion macros shared by the list engine RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop at every rising clock edge while reset is released.
`define PLE_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Check that cond never holds.
`define PLE_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  `PLE_ASSERT(label, clk, rst_n, !(cond), msg)

`endif

>>> design/ple_pkg.sv
// Types and constants of the positional list engine.
`timescale 1ns / 1ps
`default_nettype none

package ple_pkg;

  localparam int CAPACITY_DEF   = 32;
  localparam int DATA_WIDTH_DEF = 32;

  localparam int CMD_W     = 3;
  localparam int VALUE_W   = 32;
  localparam int POS_W     = 6;
  localparam int STATUS_W  = 2;
  localparam int COUNT_W   = 6;
  localparam int ELEM_W    = 32;
  localparam int S_TDATA_W = 40;
  localparam int M_TDATA_W = 40;

  typedef enum logic [CMD_W-1:0] {
    CMD_INS_FRONT = 3'd0,
    CMD_INS_BACK  = 3'd1,
    CMD_INS_AT    = 3'd2,
    CMD_DEL_FRONT = 3'd3,
    CMD_DEL_BACK  = 3'd4,
    CMD_DEL_AT    = 3'd5,
    CMD_DUMP      = 3'd6
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STS_DONE   = 2'd0,
    STS_BADPOS = 2'd1,
    STS_FULL   = 2'd2,
    STS_EMPTY  = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_WALK,
    ST_ILINK,
    ST_IFIX,
    ST_DLINK,
    ST_DREAD,
    ST_DEMIT,
    ST_RESP
  } state_e;

  typedef enum logic [1:0] {
    DK_HEAD,
    DK_TAIL,
    DK_MID
  } del_kind_e;

endpackage

`default_nettype wire

>>> design/positional_list_engine_unit.sv
// Positional list engine: doubly linked list of signed values in a slot store.
//
// Request channel (s_axis): tuser carries the command, tdata the value and the
// 1-based position. Result channel (m_axis): tuser carries the status, tdata
// the count after the command and the dumped element, tlast marks the final
// result of a command. A transfer happens when tvalid and tready are high.
// A small sequencer drives one shared read port on the link and value
// memories, following one link per cycle. An insert that lands at either
// end, deleting the only value, a rejected request and a dump of an empty
// list are settled in the check state; a delete at the front or back of a
// longer list first reads that end slot, an insert or delete at an inner
// position walks from the head to it, and a dump reads, then emits, each element.
// One request is worked at a time; s_axis_tready is high only while idle.
// A finished result sits in an output register, so the next request is
// taken while that result waits. If the receiver stalls, the engine holds
// its next result and stops until the output register frees up.
// Reset empties the list at once (free map set, count zero); the memories
// are not cleared, since only slots that hold list members are ever read.
`timescale 1ns / 1ps
`default_nettype none

module positional_list_engine_unit #(
  parameter int CAPACITY   = ple_pkg::CAPACITY_DEF,
  parameter int DATA_WIDTH = ple_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // value [31:0], position [37:32], zero fill [39:38]
  input  wire logic [ple_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  // cmd [2:0]
  input  wire logic [ple_pkg::CMD_W-1:0]       s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // count [5:0], element [37:6], zero fill [39:38]
  output logic [ple_pkg::M_TDATA_W-1:0]        m_axis_tdata,
  // status [1:0]
  output logic [ple_pkg::STATUS_W-1:0]         m_axis_tuser,
  output logic                                 m_axis_tlast
);

  import ple_pkg::*;

  `include "assert_macros.svh"

  localparam int SW   = $clog2(CAPACITY);
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW + 1 > POS_W + 1) ? CW + 1 : POS_W + 1;

  localparam logic [CMPW-1:0] ONE_X = CMPW'(1);
  localparam logic [CMPW-1:0] TWO_X = CMPW'(2);
  localparam logic [CMPW-1:0] CAP_X = CMPW'(CAPACITY);

  // Slot store
  logic [DATA_WIDTH-1:0] val_mem  [CAPACITY];
  logic [SW-1:0]         next_mem [CAPACITY];
  logic [SW-1:0]         prev_mem [CAPACITY];

  state_e                state_q, state_d;
  state_e                post_q, post_d;
  cmd_e                  cmd_q, cmd_d;
  del_kind_e             dkind_q, dkind_d;
  status_e               status_q, status_d;
  logic [DATA_WIDTH-1:0] val_q, val_d;
  logic [POS_W-1:0]      pos_q, pos_d;
  logic [SW-1:0]         head_q, head_d;
  logic [SW-1:0]         tail_q, tail_d;
  logic [CAPACITY-1:0]   free_q, free_d;
  logic [CW-1:0]         count_q, count_d;
  logic [CW-1:0]         sent_q, sent_d;
  logic [SW-1:0]         cur_q, cur_d;
  logic                  first_q, first_d;
  logic [CMPW-1:0]       rem_q, rem_d;
  logic [SW-1:0]         tgt_q, tgt_d;
  logic [SW-1:0]         new_q, new_d;

  logic                  out_valid_q, out_valid_d;
  status_e               out_status_q, out_status_d;
  logic [COUNT_W-1:0]    out_count_q, out_count_d;
  logic [ELEM_W-1:0]     out_elem_q, out_elem_d;
  logic                  out_last_q, out_last_d;

  logic [SW-1:0]         rd_next_q, rd_prev_q;
  logic [DATA_WIDTH-1:0] rd_val_q;

  logic                  rd_en;
  logic [SW-1:0]         rd_addr;
  logic                  vw_en, nw_en, pw_en;
  logic [SW-1:0]         vw_addr, nw_addr, pw_addr;
  logic [SW-1:0]         nw_data, pw_data;

  logic [CAPACITY-1:0]   free_iso;
  logic [SW-1:0]         alloc_slot;
  logic [SW-1:0]         cur_slot;
  logic                  out_free;
  logic [CMPW-1:0]       cnt_x, pos_x, p_x;
  logic                  is_ins, is_del, dump_last;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = M_TDATA_W'({out_elem_q, out_count_q});

  assign out_free = !out_valid_q || m_axis_tready;
  assign cur_slot = first_q ? cur_q : rd_next_q;
  assign cnt_x    = CMPW'(count_q);
  assign pos_x    = CMPW'(pos_q);
  assign dump_last = ((sent_q + CW'(1)) == count_q);

  always_comb begin
    free_iso   = free_q & (~free_q + CAPACITY'(1));
    alloc_slot = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (free_iso[i]) begin
        alloc_slot = alloc_slot | SW'(i);
      end
    end
  end

  always_comb begin
    is_ins = 1'b0;
    is_del = 1'b0;
    p_x    = '0;
    case (cmd_q)
      CMD_INS_FRONT: begin
        is_ins = 1'b1;
        p_x    = ONE_X;
      end
      CMD_INS_BACK: begin
        is_ins = 1'b1;
        p_x    = cnt_x + ONE_X;
      end
      CMD_INS_AT: begin
        is_ins = 1'b1;
        p_x    = pos_x;
      end
      CMD_DEL_FRONT: begin
        is_del = 1'b1;
        p_x    = ONE_X;
      end
      CMD_DEL_BACK: begin
        is_del = 1'b1;
        p_x    = cnt_x;
      end
      CMD_DEL_AT: begin
        is_del = 1'b1;
        p_x    = pos_x;
      end
      default: begin
        is_ins = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_d      = state_q;
    post_d       = post_q;
    cmd_d        = cmd_q;
    dkind_d      = dkind_q;
    status_d     = status_q;
    val_d        = val_q;
    pos_d        = pos_q;
    head_d       = head_q;
    tail_d       = tail_q;
    free_d       = free_q;
    count_d      = count_q;
    sent_d       = sent_q;
    cur_d        = cur_q;
    first_d      = first_q;
    rem_d        = rem_q;
    tgt_d        = tgt_q;
    new_d        = new_q;
    out_valid_d  = out_valid_q && !m_axis_tready;
    out_status_d = out_status_q;
    out_count_d  = out_count_q;
    out_elem_d   = out_elem_q;
    out_last_d   = out_last_q;
    rd_en        = 1'b0;
    rd_addr      = cur_slot;
    vw_en        = 1'b0;
    vw_addr      = alloc_slot;
    nw_en        = 1'b0;
    nw_addr      = alloc_slot;
    nw_data      = head_q;
    pw_en        = 1'b0;
    pw_addr      = head_q;
    pw_data      = alloc_slot;

    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          cmd_d   = cmd_e'(s_axis_tuser);
          val_d   = DATA_WIDTH'($signed(s_axis_tdata[VALUE_W-1:0]));
          pos_d   = s_axis_tdata[VALUE_W +: POS_W];
          state_d = ST_CHECK;
        end
      end

      ST_CHECK: begin
        status_d = STS_DONE;
        state_d  = ST_RESP;
        first_d  = 1'b1;
        if (is_ins) begin
          if (p_x < ONE_X || p_x > cnt_x + ONE_X) begin
            status_d = STS_BADPOS;
          end else if (cnt_x == CAP_X) begin
            status_d = STS_FULL;
          end else begin
            vw_en              = 1'b1;
            free_d[alloc_slot] = 1'b0;
            count_d            = count_q + CW'(1);
            new_d              = alloc_slot;
            if (count_q == '0) begin
              head_d = alloc_slot;
              tail_d = alloc_slot;
            end else if (p_x == ONE_X) begin
              nw_en   = 1'b1;
              nw_data = head_q;
              pw_en   = 1'b1;
              pw_addr = head_q;
              head_d  = alloc_slot;
            end else if (p_x == cnt_x + ONE_X) begin
              pw_en   = 1'b1;
              pw_addr = alloc_slot;
              pw_data = tail_q;
              nw_en   = 1'b1;
              nw_addr = tail_q;
              nw_data = alloc_slot;
              tail_d  = alloc_slot;
            end else begin
              cur_d   = head_q;
              rem_d   = p_x - TWO_X;
              post_d  = ST_ILINK;
              state_d = ST_WALK;
            end
          end
        end else if (is_del) begin
          if (count_q == '0) begin
            status_d = STS_EMPTY;
          end else if (p_x < ONE_X || p_x > cnt_x) begin
            status_d = STS_BADPOS;
          end else if (count_q == CW'(1)) begin
            free_d[head_q] = 1'b1;
            count_d        = '0;
            head_d         = '0;
            tail_d         = '0;
          end else begin
            post_d  = ST_DLINK;
            state_d = ST_WALK;
            if (p_x == ONE_X) begin
              cur_d   = head_q;
              rem_d   = '0;
              dkind_d = DK_HEAD;
            end else if (p_x == cnt_x) begin
              cur_d   = tail_q;
              rem_d   = '0;
              dkind_d = DK_TAIL;
            end else begin
              cur_d   = head_q;
              rem_d   = p_x - ONE_X;
              dkind_d = DK_MID;
            end
          end
        end else if (cmd_q == CMD_DUMP && count_q != '0) begin
          cur_d   = head_q;
          sent_d  = '0;
          state_d = ST_DREAD;
        end
      end

      ST_WALK: begin
        rd_en   = 1'b1;
        rd_addr = cur_slot;
        tgt_d   = cur_slot;
        cur_d   = cur_slot;
        first_d = 1'b0;
        if (rem_q == '0) begin
          state_d = post_q;
        end else begin
          rem_d = rem_q - ONE_X;
        end
      end

      ST_ILINK: begin
        nw_en   = 1'b1;
        nw_addr = new_q;
        nw_data = rd_next_q;
        pw_en   = 1'b1;
        pw_addr = rd_next_q;
        pw_data = new_q;
        state_d = ST_IFIX;
      end

      ST_IFIX: begin
        pw_en   = 1'b1;
        pw_addr = new_q;
        pw_data = tgt_q;
        nw_en   = 1'b1;
        nw_addr = tgt_q;
        nw_data = new_q;
        state_d = ST_RESP;
      end

      ST_DLINK: begin
        free_d[tgt_q] = 1'b1;
        count_d       = count_q - CW'(1);
        state_d       = ST_RESP;
        case (dkind_q)
          DK_HEAD: head_d = rd_next_q;
          DK_TAIL: tail_d = rd_prev_q;
          DK_MID: begin
            nw_en   = 1'b1;
            nw_addr = rd_prev_q;
            nw_data = rd_next_q;
            pw_en   = 1'b1;
            pw_addr = rd_next_q;
            pw_data = rd_prev_q;
          end
          default: head_d = head_q;
        endcase
      end

      ST_DREAD: begin
        rd_en   = 1'b1;
        rd_addr = cur_q;
        state_d = ST_DEMIT;
      end

      ST_DEMIT: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = STS_DONE;
          out_count_d  = COUNT_W'(count_q);
          out_elem_d   = ELEM_W'(rd_val_q);
          out_last_d   = dump_last;
          sent_d       = sent_q + CW'(1);
          if (dump_last) begin
            state_d = ST_IDLE;
          end else begin
            cur_d   = rd_next_q;
            state_d = ST_DREAD;
          end
        end
      end

      ST_RESP: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = status_q;
          out_count_d  = COUNT_W'(count_q);
          out_elem_d   = '0;
          out_last_d   = 1'b1;
          state_d      = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      free_q      <= '1;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      free_q      <= free_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    post_q       <= post_d;
    cmd_q        <= cmd_d;
    dkind_q      <= dkind_d;
    status_q     <= status_d;
    val_q        <= val_d;
    pos_q        <= pos_d;
    sent_q       <= sent_d;
    cur_q        <= cur_d;
    first_q      <= first_d;
    rem_q        <= rem_d;
    tgt_q        <= tgt_d;
    new_q        <= new_d;
    out_status_q <= out_status_d;
    out_count_q  <= out_count_d;
    out_elem_q   <= out_elem_d;
    out_last_q   <= out_last_d;
  end

  always_ff @(posedge clk_i) begin
    if (vw_en) begin
      val_mem[vw_addr] <= val_q;
    end
    if (rd_en) begin
      rd_val_q <= val_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (nw_en) begin
      next_mem[nw_addr] <= nw_data;
    end
    if (rd_en) begin
      rd_next_q <= next_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pw_en) begin
      prev_mem[pw_addr] <= pw_data;
    end
    if (rd_en) begin
      rd_prev_q <= prev_mem[rd_addr];
    end
  end

  `PLE_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= CW'(CAPACITY), "count above capacity")
  `PLE_ASSERT(a_free_matches_count, clk_i, rst_ni,
              $countones(free_q) == CAPACITY - int'(count_q), "free map disagrees with count")
  `PLE_ASSERT(a_empty_ends, clk_i, rst_ni,
              (count_q == '0) |-> (head_q == '0 && tail_q == '0), "empty list with stale ends")
  `PLE_ASSERT_NEVER(a_walk_bound, clk_i, rst_ni,
                    state_q == ST_WALK && rem_q >= CAP_X, "walk longer than list")

endmodule

`default_nettype wire

>>> sim/tb_positional_list_engine_unit.sv
// Testbench of the positional list engine: directed table and random list traffic vs. a queue model.
`timescale 1ns / 1ps

module tb_positional_list_engine_unit;
  import ple_pkg::*;

  localparam int LIST_CAPACITY = CAPACITY_DEF;
  localparam int RANDOM_ITEMS  = 425;
  localparam int DRAIN_CYCLES  = 200;
  localparam int N_DIRECTED    = 25;
  localparam logic [CMD_W-1:0] CMD_SPARE = 3'd7;

  localparam logic [31:0] V_MAX  = 32'h7FFF_FFFF;
  localparam logic [31:0] V_MIN  = 32'h8000_0000;
  localparam logic [31:0] V_NEG1 = 32'hFFFF_FFFF;

  typedef struct packed {
    status_e     status;
    logic [5:0]  count;
    logic [31:0] element;
    logic        last;
  } list_result_t;

  typedef struct packed {
    logic [CMD_W-1:0] op;
    logic [31:0]      value;
    logic [5:0]       position;
    logic             typed;
    list_result_t     want;
  } request_row_t;

  typedef enum int {
    PH_GROW,
    PH_SHRINK,
    PH_MIX
  } phase_e;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;
  logic [CMD_W-1:0]     s_axis_tuser = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic [STATUS_W-1:0]  m_axis_tuser;
  logic                 m_axis_tlast;

  logic [31:0]  held_values[$];
  list_result_t expected_results[$];
  int           mismatch_count = 0;
  bit           tx_idle_on = 1'b1;
  bit           rx_idle_on = 1'b1;
  request_row_t directed_rows [N_DIRECTED];

  positional_list_engine_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #30_000_000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic void expect_outcome(status_e st, logic [31:0] elem, logic fin);
    list_result_t r;
    r.status  = st;
    r.count   = 6'(held_values.size());
    r.element = elem;
    r.last    = fin;
    expected_results.push_back(r);
  endfunction

  function automatic void predict_list_op(logic [CMD_W-1:0] op, logic [31:0] value,
                                          logic [5:0] position);
    int n;
    int at;
    n = held_values.size();
    case (op)
      CMD_INS_FRONT, CMD_INS_BACK, CMD_INS_AT: begin
        at = (op == CMD_INS_FRONT) ? 1 : (op == CMD_INS_BACK) ? n + 1 : int'(position);
        if (at < 1 || at > n + 1) begin
          expect_outcome(STS_BADPOS, '0, 1'b1);
        end else if (n >= LIST_CAPACITY) begin
          expect_outcome(STS_FULL, '0, 1'b1);
        end else begin
          held_values.insert(at - 1, value);
          expect_outcome(STS_DONE, '0, 1'b1);
        end
      end
      CMD_DEL_FRONT, CMD_DEL_BACK, CMD_DEL_AT: begin
        at = (op == CMD_DEL_FRONT) ? 1 : (op == CMD_DEL_BACK) ? n : int'(position);
        if (n == 0) begin
          expect_outcome(STS_EMPTY, '0, 1'b1);
        end else if (at < 1 || at > n) begin
          expect_outcome(STS_BADPOS, '0, 1'b1);
        end else begin
          held_values.delete(at - 1);
          expect_outcome(STS_DONE, '0, 1'b1);
        end
      end
      CMD_DUMP: begin
        if (n == 0) begin
          expect_outcome(STS_DONE, '0, 1'b1);
        end else begin
          for (int k = 0; k < n; k++) begin
            expect_outcome(STS_DONE, held_values[k], k == n - 1);
          end
        end
      end
      default: begin
        expect_outcome(STS_DONE, '0, 1'b1);
      end
    endcase
  endfunction

  task automatic send_request(logic [CMD_W-1:0] op, logic [31:0] value, logic [5:0] position,
                              logic typed, list_result_t want);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {2'b00, position, value};
    do @(posedge clk_i); while (!s_axis_tready);
    predict_list_op(op, value, position);
    if (typed) begin
      void'(expected_results.pop_back());
      expected_results.push_back(want);
    end
  endtask

  task automatic check_result();
    list_result_t got;
    list_result_t want;
    got.status  = status_e'(m_axis_tuser);
    got.count   = m_axis_tdata[5:0];
    got.element = m_axis_tdata[37:6];
    got.last    = m_axis_tlast;
    if (expected_results.size() == 0) begin
      $display("%0t: result with none pending: status %0d count %0d element %h last %b",
               $time, got.status, got.count, got.element, got.last);
      mismatch_count++;
    end else begin
      want = expected_results.pop_front();
      if (got.status !== want.status)
        $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
      if (got.count !== want.count)
        $display("%0t: count expected %0d actual %0d", $time, want.count, got.count);
      if (got.element !== want.element)
        $display("%0t: element expected %h actual %h", $time, want.element, got.element);
      if (got.last !== want.last)
        $display("%0t: last expected %b actual %b", $time, want.last, got.last);
      if (got !== want) mismatch_count++;
    end
  endtask

  initial begin : result_sink
    int stall;
    wait (rst_ni == 1'b1);
    forever begin
      stall = rx_idle_on ? $urandom_range(0, 15) : 0;
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      check_result();
    end
  end

  function automatic logic [CMD_W-1:0] pick_command(phase_e mode);
    int roll;
    int ins_lim;
    roll    = $urandom_range(0, 99);
    ins_lim = (mode == PH_GROW) ? 70 : (mode == PH_SHRINK) ? 15 : 42;
    if (roll < ins_lim) begin
      case ($urandom_range(0, 2))
        0:       return CMD_INS_FRONT;
        1:       return CMD_INS_BACK;
        default: return CMD_INS_AT;
      endcase
    end
    if (roll < 85) begin
      case ($urandom_range(0, 2))
        0:       return CMD_DEL_FRONT;
        1:       return CMD_DEL_BACK;
        default: return CMD_DEL_AT;
      endcase
    end
    if (roll < 97) return CMD_DUMP;
    return CMD_SPARE;
  endfunction

  function automatic logic [5:0] pick_position(logic [CMD_W-1:0] op);
    int span;
    span = (op == CMD_INS_AT) ? held_values.size() + 1 : held_values.size();
    if ((op != CMD_INS_AT && op != CMD_DEL_AT) || span == 0 || $urandom_range(0, 5) == 0)
      return 6'($urandom_range(0, 63));
    if ($urandom_range(0, 3) == 0)
      return ($urandom_range(0, 1) == 0) ? 6'd1 : 6'(span);
    return 6'($urandom_range(1, span));
  endfunction

  function automatic logic [31:0] pick_value();
    if ($urandom_range(0, 7) != 0) return $urandom;
    case ($urandom_range(0, 3))
      0:       return V_MAX;
      1:       return V_MIN;
      2:       return V_NEG1;
      default: return '0;
    endcase
  endfunction

  initial begin : stimulus
    int           issued;
    int           span;
    phase_e       mode;
    logic [CMD_W-1:0] op;

    directed_rows = '{
      '{CMD_DUMP,      '0,          6'd0,  1'b1, '{STS_DONE,   6'd0, 32'd0, 1'b1}},
      '{CMD_DEL_FRONT, '0,          6'd0,  1'b1, '{STS_EMPTY,  6'd0, 32'd0, 1'b1}},
      '{CMD_DEL_BACK,  V_NEG1,      6'd63, 1'b1, '{STS_EMPTY,  6'd0, 32'd0, 1'b1}},
      '{CMD_DEL_AT,    '0,          6'd0,  1'b1, '{STS_EMPTY,  6'd0, 32'd0, 1'b1}},
      '{CMD_DEL_AT,    '0,          6'd63, 1'b1, '{STS_EMPTY,  6'd0, 32'd0, 1'b1}},
      '{CMD_INS_AT,    V_MAX,       6'd0,  1'b1, '{STS_BADPOS, 6'd0, 32'd0, 1'b1}},
      '{CMD_INS_AT,    V_MAX,       6'd2,  1'b1, '{STS_BADPOS, 6'd0, 32'd0, 1'b1}},
      '{CMD_INS_AT,    V_MAX,       6'd63, 1'b1, '{STS_BADPOS, 6'd0, 32'd0, 1'b1}},
      '{CMD_INS_AT,    V_MAX,       6'd1,  1'b1, '{STS_DONE,   6'd1, 32'd0, 1'b1}},
      '{CMD_INS_BACK,  V_MIN,       6'd0,  1'b1, '{STS_DONE,   6'd2, 32'd0, 1'b1}},
      '{CMD_INS_FRONT, V_NEG1,      6'd63, 1'b1, '{STS_DONE,   6'd3, 32'd0, 1'b1}},
      '{CMD_INS_AT,    32'd1,       6'd3,  1'b1, '{STS_DONE,   6'd4, 32'd0, 1'b1}},
      '{CMD_INS_AT,    32'hAAAA_AAAA, 6'd5, 1'b1, '{STS_DONE,  6'd5, 32'd0, 1'b1}},
      '{CMD_INS_AT,    '0,          6'd7,  1'b1, '{STS_BADPOS, 6'd5, 32'd0, 1'b1}},
      '{CMD_DUMP,      '0,          6'd0,  1'b0, '0},
      '{CMD_DEL_AT,    '0,          6'd0,  1'b1, '{STS_BADPOS, 6'd5, 32'd0, 1'b1}},
      '{CMD_DEL_AT,    '0,          6'd6,  1'b1, '{STS_BADPOS, 6'd5, 32'd0, 1'b1}},
      '{CMD_DEL_AT,    '0,          6'd3,  1'b1, '{STS_DONE,   6'd4, 32'd0, 1'b1}},
      '{CMD_SPARE,     32'h5555_5555, 6'd63, 1'b1, '{STS_DONE,  6'd4, 32'd0, 1'b1}},
      '{CMD_DEL_FRONT, '0,          6'd0,  1'b1, '{STS_DONE,   6'd3, 32'd0, 1'b1}},
      '{CMD_DEL_BACK,  '0,          6'd0,  1'b1, '{STS_DONE,   6'd2, 32'd0, 1'b1}},
      '{CMD_DUMP,      '0,          6'd0,  1'b0, '0},
      '{CMD_DEL_AT,    '0,          6'd2,  1'b1, '{STS_DONE,   6'd1, 32'd0, 1'b1}},
      '{CMD_DEL_AT,    '0,          6'd1,  1'b1, '{STS_DONE,   6'd0, 32'd0, 1'b1}},
      '{CMD_DUMP,      '0,          6'd0,  1'b1, '{STS_DONE,   6'd0, 32'd0, 1'b1}}
    };

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].op, directed_rows[i].value, directed_rows[i].position,
                   directed_rows[i].typed, directed_rows[i].want);
    end

    issued = 0;
    while (issued < RANDOM_ITEMS) begin
      mode       = phase_e'($urandom_range(0, 2));
      tx_idle_on = $urandom_range(0, 3) != 0;
      rx_idle_on = $urandom_range(0, 3) != 0;
      span       = $urandom_range(10, 60);
      for (int k = 0; k < span && issued < RANDOM_ITEMS; k++) begin
        op = pick_command(mode);
        send_request(op, pick_value(), pick_position(op), 1'b0, '0);
        issued++;
      end
    end

    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
